[rtl/core/shbh_pkg.sv]
// Shared types, constants and round functions for the SHA-256 byte-stream hasher.
// Used by shbh_core and sha256_byte_stream_hasher_top; depends on nothing else.

package shbh_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned BLOCK_W = 512;
	localparam int unsigned COUNT_W = 61;
	localparam int unsigned LEN_W   = 64;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;
	localparam logic [5:0] LAST_POS  = 6'd63;
	localparam logic [5:0] LAST_RND  = 6'd63;
	localparam logic [2:0] LAST_IDX  = 3'd7;

	typedef logic [7:0][WORD_W-1:0] hash_vec_t;

	// Controls from the byte sequencer to the compression unit
	typedef struct packed {
		logic start;
		logic reinit;
	} shbh_ctrl_t;

	// Status back from the compression unit
	typedef struct packed {
		logic busy;
		logic done;
	} shbh_stat_t;

	localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [WORD_W-1:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [WORD_W-1:0] big_sig0(input logic [WORD_W-1:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WORD_W-1:0] big_sig1(input logic [WORD_W-1:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [WORD_W-1:0] small_sig0(input logic [WORD_W-1:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [WORD_W-1:0] small_sig1(input logic [WORD_W-1:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

[rtl/core/sha256_byte_stream_hasher_top.sv]
// SHA-256 byte-stream hasher top level: byte packing, padding sequencer and digest output.
// Instantiates shbh_core; uses shbh_pkg.
// Throughput: one byte beat per cycle while a block fills; the 64th byte of a block
// holds the input through start, 64 rounds on the shared round unit, hash update and
// hand-back of done.
// Sequence: after the end beat, padding runs one byte per cycle to the block end (and
// through a further block after one more compression when the length spills over),
// then eight digest beats follow, one per cycle when taken at once.
// Reset: hash words load the initial values, byte count and fill position clear.

module sha256_byte_stream_hasher_top
	import shbh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] msg_byte
	input  logic        s_tuser,  // [0] byte_present
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast   // last_word
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PAD  = 4'b0010,
		ST_COMP = 4'b0100,
		ST_OUT  = 4'b1000
	} top_state_t;

	top_state_t         state_q;
	logic [5:0]         fill_q;
	logic [COUNT_W-1:0] count_q;
	logic [LEN_W-1:0]   len_q;
	logic               first_q;
	logic               lenon_q;
	logic               fin_q;
	logic               endp_q;
	logic               start_q;
	logic [2:0]         idx_q;
	logic [BLOCK_W-1:0] blk_q;

	shbh_ctrl_t         ctrl;
	shbh_stat_t         stat;
	hash_vec_t          hash;

	logic               in_beat, out_beat, use_len, shift_en;
	logic [7:0]         shift_byte;
	logic [COUNT_W-1:0] count_nx;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;
	assign count_nx = count_q + COUNT_W'(s_tuser);

	// Length bytes go in once padding has reached the last eight positions
	assign use_len = !first_q && (lenon_q || fill_q == LEN_START);

	// Pick the byte that enters the block this cycle
	always_comb begin
		shift_en   = 1'b0;
		shift_byte = s_tdata;
		if (in_beat && s_tuser) begin
			shift_en = 1'b1;
		end else if (state_q == ST_PAD) begin
			shift_en = 1'b1;
			if (first_q) shift_byte = PAD_MARK;
			else if (use_len) shift_byte = len_q[LEN_W-1 -: 8];
			else shift_byte = 8'h00;
		end
	end

	// Shift bytes into the block, first byte ending up in the top bits
	always_ff @(posedge clk) begin
		if (shift_en) blk_q <= {blk_q[BLOCK_W-9:0], shift_byte};
	end

	// Byte sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			count_q <= '0;
			len_q   <= '0;
			first_q <= 1'b0;
			lenon_q <= 1'b0;
			fin_q   <= 1'b0;
			endp_q  <= 1'b0;
			start_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (s_tuser) begin
							fill_q  <= fill_q + 6'd1;
							count_q <= count_nx;
						end
						if (s_tlast) begin
							len_q   <= {count_nx, 3'b000};
							count_q <= '0;
							first_q <= 1'b1;
							lenon_q <= 1'b0;
						end
						if (s_tuser && fill_q == LAST_POS) begin
							start_q <= 1'b1;
							fin_q   <= 1'b0;
							endp_q  <= s_tlast;
							state_q <= ST_COMP;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q  <= fill_q + 6'd1;
					first_q <= 1'b0;
					if (use_len) begin
						len_q   <= {len_q[LEN_W-9:0], 8'h00};
						lenon_q <= 1'b1;
					end
					if (fill_q == LAST_POS) begin
						start_q <= 1'b1;
						fin_q   <= use_len;
						endp_q  <= 1'b1;
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (stat.done) begin
						idx_q <= '0;
						if (fin_q) state_q <= ST_OUT;
						else if (endp_q) state_q <= ST_PAD;
						else state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_beat) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == LAST_IDX) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign ctrl.start  = start_q;
	assign ctrl.reinit = out_beat && (idx_q == LAST_IDX);

	shbh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.blk    (blk_q),
		.stat   (stat),
		.hash   (hash)
	);

	// Digest beat from the hash words
	assign m_tdata = {5'b00000, idx_q, hash[idx_q]};
	assign m_tlast = (idx_q == LAST_IDX);

	// Input and output never open in the same cycle
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output open together");

	// A compression start is issued only on the way into the wait state
	a_start_comp: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> state_q == ST_COMP)
		else $error("start outside compression wait");

	// Digest output opens only right after a finished compression
	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(stat.done))
		else $error("digest shown before compression finished");

	// The final block always ends on a block boundary
	a_out_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> fill_q == '0)
		else $error("digest shown with partial block");

endmodule

[rtl/core/shbh_core.sv]
// SHA-256 compression unit: one shared round datapath reused for 64 rounds per block,
// with a 16-word rolling schedule line and the running hash words. Uses shbh_pkg.

module shbh_core
	import shbh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  shbh_ctrl_t         ctrl,
	input  logic [BLOCK_W-1:0] blk,
	output shbh_stat_t         stat,
	output hash_vec_t          hash
);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_ADD  = 3'b100
	} core_state_t;

	core_state_t       state_q;
	logic [5:0]        round_q;
	logic              done_q;
	hash_vec_t         hash_q;
	logic [WORD_W-1:0] w_q [16];
	logic [WORD_W-1:0] v_q [8];

	logic [WORD_W-1:0] t1, t2, ch, maj, w_new;

	// Round datapath on the current working variables
	always_comb begin
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + big_sig1(v_q[4]) + ch + ROUND_K[round_q] + w_q[0];
		t2    = big_sig0(v_q[0]) + maj;
		w_new = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];
	end

	// Sequencer, round count and hash words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			round_q <= '0;
			done_q  <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[i] <= INIT_HASH[i];
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (ctrl.reinit) begin
						for (int i = 0; i < 8; i++) hash_q[i] <= INIT_HASH[i];
					end
					if (ctrl.start) begin
						round_q <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					round_q <= round_q + 6'd1;
					if (round_q == LAST_RND) state_q <= C_ADD;
				end
				C_ADD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// Load the block and chaining value, then advance one round per cycle
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && ctrl.start) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk[BLOCK_W-1-WORD_W*i -: WORD_W];
			for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
		end else if (state_q == C_RUN) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign stat.busy = (state_q != C_IDLE);
	assign stat.done = done_q;
	assign hash      = hash_q;

	// A block must not be started while rounds are in flight
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> !stat.busy)
		else $error("compression started while busy");

	// The final round hands over to the hash update
	a_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_RUN && round_q == LAST_RND) |=> state_q == C_ADD)
		else $error("round sequence did not end in hash update");

	// Done follows the hash update only
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == C_ADD))
		else $error("done without hash update");

endmodule
